// ----- rtl/polyline_point_tangent_normal_assert.svh -----
// Assertion macros for the polyline point, tangent and normal evaluator.
`ifndef POLYLINE_POINT_TANGENT_NORMAL_ASSERT_SVH
`define POLYLINE_POINT_TANGENT_NORMAL_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define PPTN_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define PPTN_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/pptn_pkg.sv -----
// Package with types, codes and helpers of the polyline point, tangent and normal evaluator.
`timescale 1ns / 1ps

package pptn_pkg;

    localparam int MAX_POINTS = 256;
    localparam int FRAC_BITS  = 16;
    localparam int UNIT_BITS  = 24;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_EVAL  = 1'b1;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FEW   = 2'd1;
    localparam logic [1:0] STATUS_CLAMP = 2'd2;
    localparam logic [1:0] STATUS_RANGE = 2'd3;

    localparam logic [1:0] REG_POINT_COUNT  = 2'd0;
    localparam logic [1:0] REG_SNAP_EPSILON = 2'd1;
    localparam logic [1:0] REG_AXIS_EPSILON = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SNAP,
        ST_READ,
        ST_PMUL,
        ST_PADD,
        ST_TSEG,
        ST_SQ,
        ST_SQRT,
        ST_DIV,
        ST_KMUL,
        ST_KRND,
        ST_NORM,
        ST_DONE
    } pptn_state_t;

    function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
        logic signed [31:0] r;
        if (v > 40'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -40'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [31:0] neg_sat32(input logic signed [31:0] v);
        logic signed [31:0] r;
        if (v == 32'sh80000000) begin
            r = 32'sh7FFFFFFF;
        end else begin
            r = -v;
        end
        return r;
    endfunction

    function automatic logic [32:0] mag33(input logic signed [32:0] v);
        logic [32:0] r;
        r = v[32] ? (~v + 33'd1) : v;
        return r;
    endfunction

    function automatic logic signed [31:0] comp(input logic [95:0] v, input logic [1:0] c);
        logic signed [31:0] r;
        case (c)
            2'd0: r = v[31:0];
            2'd1: r = v[63:32];
            default: r = v[95:64];
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/polyline_point_tangent_normal.sv -----
// Top level of the polyline point, tangent and normal evaluator.
`timescale 1ns / 1ps

// The block holds up to 256 vertices in a single-port-read memory and answers
// write and evaluate transactions one at a time. An evaluate reads five
// vertices, one per cycle. Exactly at an interior knot it also runs two
// bit-serial square roots of 34 steps each and six restoring divisions of
// 25 steps each on one shared divider. A finished result waits in the output
// register while the next transaction is accepted.
module polyline_point_tangent_normal
    import pptn_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_opcode,
    input  logic [7:0]         s_vertex_index,
    input  logic signed [31:0] s_coord_x,
    input  logic signed [31:0] s_coord_y,
    input  logic signed [31:0] s_coord_z,
    input  logic [23:0]        s_param_u,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_point_x,
    output logic signed [31:0] m_point_y,
    output logic signed [31:0] m_point_z,
    output logic signed [31:0] m_tangent_x,
    output logic signed [31:0] m_tangent_y,
    output logic signed [31:0] m_tangent_z,
    output logic signed [31:0] m_normal_x,
    output logic signed [31:0] m_normal_y,
    output logic signed [31:0] m_normal_z,
    output logic [1:0]         m_status
);

    pptn_state_t state_reg, state_next;

    logic [8:0]  point_count_reg;
    logic [15:0] snap_epsilon_reg;
    logic [15:0] axis_epsilon_reg;

    logic [95:0] mem [MAX_POINTS];
    logic [95:0] mem_q;
    logic        mem_re;
    logic [7:0]  mem_raddr;

    logic [8:0]  n_reg;
    logic [23:0] last_reg;
    logic [23:0] u_reg;
    logic [1:0]  status_reg;
    logic [7:0]  seg_reg;
    logic [15:0] f_reg;
    logic [7:0]  ta_reg;
    logic        knot_reg;
    logic [95:0] v_reg [5];
    logic [2:0]  rd_cnt_reg;
    logic        rdv_reg;
    logic [2:0]  rdidx_reg;
    logic [2:0]  cnt_reg;
    logic [5:0]  step_reg;
    logic [65:0] mul_reg;
    logic [66:0] acc_a_reg;
    logic [66:0] acc_b_reg;
    logic [67:0] rad_reg;
    logic [35:0] rem_reg;
    logic [33:0] root_reg;
    logic [33:0] la_reg;
    logic [33:0] lb_reg;
    logic [33:0] drem_reg;
    logic [24:0] q_reg;
    logic [24:0] ua_reg [3];
    logic [24:0] ub_reg [3];
    logic        sneg_reg;
    logic signed [31:0] pt_reg [3];
    logic signed [31:0] tan_reg [3];
    logic signed [31:0] nrm_reg [3];
    logic        m_valid_reg;
    logic signed [31:0] m_pt_reg [3];
    logic signed [31:0] m_tan_reg [3];
    logic signed [31:0] m_nrm_reg [3];
    logic [1:0]  m_status_reg;

    logic        cfg_we;
    logic        s_fire;
    logic        out_free;
    logic [8:0]  n_in;
    logic [23:0] last_in;
    logic [23:0] pu_c;
    logic signed [32:0] dp [3];
    logic signed [32:0] da [3];
    logic signed [32:0] db [3];
    logic [1:0]  ci;
    logic [32:0] sq_in;
    logic [65:0] sq_prod;
    logic [48:0] pt_prod;
    logic [48:0] pt_rnd;
    logic signed [34:0] pt_sum;
    logic [36:0] sq_rem2;
    logic [36:0] sq_trial;
    logic [33:0] root_new;
    logic [35:0] rem_new;
    logic [32:0] dv_x;
    logic [33:0] dv_len;
    logic        dv_neg_a;
    logic [34:0] dv_rem2;
    logic [24:0] q_new;
    logic [33:0] drem_new;
    logic signed [26:0] k_sum;
    logic [25:0] k_mag;
    logic [34:0] l_sum;
    logic [60:0] k_prod;
    logic [60:0] k_rnd;
    logic signed [37:0] k_val;
    logic [31:0] abs_tx;
    logic [31:0] abs_ty;
    logic        near_z;

    assign pready   = 1'b1;
    assign cfg_we   = psel && penable && pwrite && pready;
    assign s_fire   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        case (paddr[3:2])
            REG_POINT_COUNT:  prdata = {23'd0, point_count_reg};
            REG_SNAP_EPSILON: prdata = {16'd0, snap_epsilon_reg};
            REG_AXIS_EPSILON: prdata = {16'd0, axis_epsilon_reg};
            default:          prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            point_count_reg  <= 9'd0;
            snap_epsilon_reg <= 16'd1;
            axis_epsilon_reg <= 16'd1;
        end else if (cfg_we) begin
            case (paddr[3:2])
                REG_POINT_COUNT:  point_count_reg  <= pwdata[8:0];
                REG_SNAP_EPSILON: snap_epsilon_reg <= pwdata[15:0];
                REG_AXIS_EPSILON: axis_epsilon_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    assign n_in    = (point_count_reg > 9'(MAX_POINTS)) ? 9'(MAX_POINTS) : point_count_reg;
    assign last_in = {8'(n_in - 9'd1), 16'd0};

    always_comb begin
        if (u_reg < {8'd0, snap_epsilon_reg}) begin
            pu_c = 24'd0;
        end else if ((last_reg - u_reg) < {8'd0, snap_epsilon_reg}) begin
            pu_c = last_reg;
        end else begin
            pu_c = u_reg;
        end
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            dp[c] = 33'(comp(v_reg[1], 2'(c))) - 33'(comp(v_reg[0], 2'(c)));
            da[c] = 33'(comp(v_reg[3], 2'(c))) - 33'(comp(v_reg[2], 2'(c)));
            db[c] = 33'(comp(v_reg[4], 2'(c))) - 33'(comp(v_reg[3], 2'(c)));
        end
    end

    assign mem_re = (state_reg == ST_READ) && (rd_cnt_reg < 3'd5);

    always_comb begin
        case (rd_cnt_reg)
            3'd0:    mem_raddr = seg_reg;
            3'd1:    mem_raddr = seg_reg + 8'd1;
            3'd2:    mem_raddr = ta_reg;
            3'd3:    mem_raddr = ta_reg + 8'd1;
            default: mem_raddr = ta_reg + 8'd2;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (s_fire && (s_opcode == OP_WRITE)) begin
            mem[s_vertex_index] <= {s_coord_z, s_coord_y, s_coord_x};
        end
        if (mem_re) begin
            mem_q <= mem[mem_raddr];
        end
    end

    assign ci      = (cnt_reg < 3'd3) ? cnt_reg[1:0] : 2'(cnt_reg - 3'd3);
    assign pt_prod = mag33(dp[cnt_reg[1:0]]) * f_reg;
    assign pt_rnd  = mul_reg[48:0] + 49'h8000;
    assign pt_sum  = dp[cnt_reg[1:0]][32]
                   ? 35'(comp(v_reg[0], cnt_reg[1:0])) - 35'({1'b0, pt_rnd[48:16]})
                   : 35'(comp(v_reg[0], cnt_reg[1:0])) + 35'({1'b0, pt_rnd[48:16]});

    assign sq_in   = (cnt_reg < 3'd3) ? mag33(da[ci]) : mag33(db[ci]);
    assign sq_prod = sq_in * sq_in;

    assign sq_rem2  = {rem_reg[34:0], rad_reg[67:66]};
    assign sq_trial = {1'b0, root_reg, 2'b01};
    always_comb begin
        if (sq_rem2 >= sq_trial) begin
            rem_new  = 36'(sq_rem2 - sq_trial);
            root_new = {root_reg[32:0], 1'b1};
        end else begin
            rem_new  = sq_rem2[35:0];
            root_new = {root_reg[32:0], 1'b0};
        end
    end

    assign dv_x     = (cnt_reg < 3'd3) ? mag33(da[ci]) : mag33(db[ci]);
    assign dv_len   = (cnt_reg < 3'd3) ? la_reg : lb_reg;
    assign dv_rem2  = {drem_reg, 1'b0};
    always_comb begin
        if (step_reg == 6'd0) begin
            if ({1'b0, dv_x} >= dv_len) begin
                q_new    = 25'd1;
                drem_new = {1'b0, dv_x} - dv_len;
            end else begin
                q_new    = 25'd0;
                drem_new = {1'b0, dv_x};
            end
        end else if (dv_rem2 >= {1'b0, dv_len}) begin
            q_new    = {q_reg[23:0], 1'b1};
            drem_new = 34'(dv_rem2 - {1'b0, dv_len});
        end else begin
            q_new    = {q_reg[23:0], 1'b0};
            drem_new = dv_rem2[33:0];
        end
    end
    assign dv_neg_a = 1'b0;

    assign k_sum  = (da[cnt_reg[1:0]][32] ? -27'(ua_reg[cnt_reg[1:0]]) : 27'(ua_reg[cnt_reg[1:0]]))
                  + (db[cnt_reg[1:0]][32] ? -27'(ub_reg[cnt_reg[1:0]]) : 27'(ub_reg[cnt_reg[1:0]]));
    assign k_mag  = k_sum[26] ? 26'(-k_sum) : k_sum[25:0];
    assign l_sum  = {1'b0, la_reg} + {1'b0, lb_reg};
    assign k_prod = k_mag * l_sum;
    assign k_rnd  = mul_reg[60:0] + 61'h1000000;
    assign k_val  = sneg_reg ? -38'({2'b0, k_rnd[60:25]}) : 38'({2'b0, k_rnd[60:25]});

    assign abs_tx = tan_reg[0][31] ? (~tan_reg[0] + 32'd1) : tan_reg[0];
    assign abs_ty = tan_reg[1][31] ? (~tan_reg[1] + 32'd1) : tan_reg[1];
    assign near_z = (abs_tx < {16'd0, axis_epsilon_reg}) && (abs_ty < {16'd0, axis_epsilon_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_opcode == OP_WRITE || n_in < 9'd2) begin
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_SNAP;
                    end
                end
            end
            ST_SNAP: state_next = ST_READ;
            ST_READ: begin
                if (rdv_reg && rdidx_reg == 3'd4) begin
                    state_next = ST_PMUL;
                end
            end
            ST_PMUL: state_next = ST_PADD;
            ST_PADD: begin
                if (cnt_reg == 3'd2) begin
                    state_next = knot_reg ? ST_SQ : ST_TSEG;
                end else begin
                    state_next = ST_PMUL;
                end
            end
            ST_TSEG: state_next = ST_NORM;
            ST_SQ: begin
                if (cnt_reg == 3'd6) begin
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT: begin
                if (step_reg == 6'd33 && cnt_reg == 3'd1) begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (step_reg == 6'(UNIT_BITS) && cnt_reg == 3'd5) begin
                    state_next = ST_KMUL;
                end
            end
            ST_KMUL: state_next = ST_KRND;
            ST_KRND: begin
                state_next = (cnt_reg == 3'd2) ? ST_NORM : ST_KMUL;
            end
            ST_NORM: state_next = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    for (int c = 0; c < 3; c++) begin
                        pt_reg[c]  <= 32'sd0;
                        tan_reg[c] <= 32'sd0;
                        nrm_reg[c] <= 32'sd0;
                    end
                    n_reg    <= n_in;
                    last_reg <= last_in;
                    if (s_opcode == OP_WRITE) begin
                        status_reg <= ({1'b0, s_vertex_index} >= 9'(MAX_POINTS))
                                    ? STATUS_RANGE : STATUS_OK;
                    end else if (n_in < 9'd2) begin
                        status_reg <= STATUS_FEW;
                    end else if (s_param_u > last_in) begin
                        status_reg <= STATUS_CLAMP;
                        u_reg      <= last_in;
                    end else begin
                        status_reg <= STATUS_OK;
                        u_reg      <= s_param_u;
                    end
                end
            end
            ST_SNAP: begin
                seg_reg    <= pu_c[23:16];
                f_reg      <= pu_c[15:0];
                rd_cnt_reg <= 3'd0;
                rdv_reg    <= 1'b0;
                if (u_reg == 24'd0) begin
                    ta_reg   <= 8'd0;
                    knot_reg <= 1'b0;
                end else if (u_reg >= last_reg) begin
                    ta_reg   <= 8'(n_reg - 9'd2);
                    knot_reg <= 1'b0;
                end else if (u_reg[15:0] == 16'd0) begin
                    ta_reg   <= u_reg[23:16] - 8'd1;
                    knot_reg <= 1'b1;
                end else begin
                    ta_reg   <= u_reg[23:16];
                    knot_reg <= 1'b0;
                end
            end
            ST_READ: begin
                rdv_reg   <= mem_re;
                rdidx_reg <= rd_cnt_reg;
                if (mem_re) begin
                    rd_cnt_reg <= rd_cnt_reg + 3'd1;
                end
                if (rdv_reg) begin
                    v_reg[rdidx_reg] <= mem_q;
                end
                cnt_reg <= 3'd0;
            end
            ST_PMUL: begin
                mul_reg <= 66'(pt_prod);
            end
            ST_PADD: begin
                if (f_reg == 16'd0) begin
                    pt_reg[cnt_reg[1:0]] <= comp(v_reg[0], cnt_reg[1:0]);
                end else begin
                    pt_reg[cnt_reg[1:0]] <= sat32(40'(pt_sum));
                end
                cnt_reg <= (cnt_reg == 3'd2) ? 3'd0 : cnt_reg + 3'd1;
            end
            ST_TSEG: begin
                for (int c = 0; c < 3; c++) begin
                    tan_reg[c] <= sat32(40'(da[c]));
                end
            end
            ST_SQ: begin
                if (cnt_reg < 3'd6) begin
                    mul_reg <= sq_prod;
                end
                if (cnt_reg == 3'd0) begin
                    acc_a_reg <= 67'd0;
                    acc_b_reg <= 67'd0;
                end else if (cnt_reg <= 3'd3) begin
                    acc_a_reg <= acc_a_reg + 67'(mul_reg);
                end else begin
                    acc_b_reg <= acc_b_reg + 67'(mul_reg);
                end
                if (cnt_reg == 3'd6) begin
                    cnt_reg  <= 3'd0;
                    step_reg <= 6'd0;
                    rad_reg  <= {1'b0, acc_a_reg};
                    rem_reg  <= 36'd0;
                    root_reg <= 34'd0;
                end else begin
                    cnt_reg <= cnt_reg + 3'd1;
                end
            end
            ST_SQRT: begin
                if (step_reg == 6'd33) begin
                    step_reg <= 6'd0;
                    rem_reg  <= 36'd0;
                    root_reg <= 34'd0;
                    if (cnt_reg == 3'd0) begin
                        la_reg  <= root_new;
                        rad_reg <= {1'b0, acc_b_reg};
                        cnt_reg <= 3'd1;
                    end else begin
                        lb_reg  <= root_new;
                        cnt_reg <= 3'd0;
                    end
                end else begin
                    rem_reg  <= rem_new;
                    root_reg <= root_new;
                    rad_reg  <= {rad_reg[65:0], 2'b00};
                    step_reg <= step_reg + 6'd1;
                end
            end
            ST_DIV: begin
                q_reg    <= q_new;
                drem_reg <= drem_new;
                if (step_reg == 6'(UNIT_BITS)) begin
                    step_reg <= 6'd0;
                    if (cnt_reg < 3'd3) begin
                        ua_reg[ci] <= (dv_len == 34'd0 || dv_neg_a) ? 25'd0 : q_new;
                    end else begin
                        ub_reg[ci] <= (dv_len == 34'd0) ? 25'd0 : q_new;
                    end
                    cnt_reg <= (cnt_reg == 3'd5) ? 3'd0 : cnt_reg + 3'd1;
                end else begin
                    step_reg <= step_reg + 6'd1;
                end
            end
            ST_KMUL: begin
                mul_reg  <= 66'(k_prod);
                sneg_reg <= k_sum[26];
            end
            ST_KRND: begin
                tan_reg[cnt_reg[1:0]] <= sat32(40'(k_val));
                cnt_reg <= (cnt_reg == 3'd2) ? 3'd0 : cnt_reg + 3'd1;
            end
            ST_NORM: begin
                if (near_z) begin
                    nrm_reg[0] <= 32'sd0;
                    nrm_reg[1] <= tan_reg[2];
                    nrm_reg[2] <= neg_sat32(tan_reg[1]);
                end else begin
                    nrm_reg[0] <= tan_reg[1];
                    nrm_reg[1] <= neg_sat32(tan_reg[0]);
                    nrm_reg[2] <= 32'sd0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_DONE && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_DONE && out_free) begin
            m_pt_reg     <= pt_reg;
            m_tan_reg    <= tan_reg;
            m_nrm_reg    <= nrm_reg;
            m_status_reg <= status_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_point_x   = m_pt_reg[0];
    assign m_point_y   = m_pt_reg[1];
    assign m_point_z   = m_pt_reg[2];
    assign m_tangent_x = m_tan_reg[0];
    assign m_tangent_y = m_tan_reg[1];
    assign m_tangent_z = m_tan_reg[2];
    assign m_normal_x  = m_nrm_reg[0];
    assign m_normal_y  = m_nrm_reg[1];
    assign m_normal_z  = m_nrm_reg[2];
    assign m_status    = m_status_reg;

`include "polyline_point_tangent_normal_assert.svh"

    `PPTN_ASSERT_SAME(a_few_is_zero, m_valid && m_status == STATUS_FEW, m_point_x == 32'sd0 && m_tangent_x == 32'sd0 && m_normal_y == 32'sd0, "Short polyline transaction returned nonzero data.")
    `PPTN_ASSERT_SAME(a_normal_axis, m_valid, m_normal_x == 32'sd0 || m_normal_z == 32'sd0, "Normal has no zero component.")
    `PPTN_ASSERT_NEXT(a_write_done, s_valid && s_ready && s_opcode == OP_WRITE, state_reg == ST_DONE, "Write transaction did not complete directly.")

endmodule
